>>> rtl/lcfd_pkg.sv
// shared constants, types and the full-scale table of the loop current flow display
package lcfd_pkg;

   localparam int SAMPLE_BITS    = 10;
   localparam int TICK_BITS      = 16;
   localparam int FLASH_BITS     = 16;
   localparam int RANGE_BITS     = 3;
   localparam int DIGIT_BITS     = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = (SAMPLE_BITS > FLASH_BITS) ? SAMPLE_BITS : FLASH_BITS;
   localparam int CMP_BITS       = (TICK_BITS > FLASH_BITS) ? TICK_BITS : FLASH_BITS;

   // full-scale flow needs 9 bits; numerator 2*num*fs + span
   localparam int FS_BITS  = 9;
   localparam int NUM_BITS = SAMPLE_BITS + FS_BITS + 2;
   localparam int DIV_BITS = SAMPLE_BITS + 1;
   localparam int VAL_BITS = 14;
   localparam int BCD_BITS = 4 * DIGIT_BITS;
   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   localparam logic [VAL_BITS-1:0]    MAX_SHOWN      = VAL_BITS'(9999);
   localparam logic [SAMPLE_BITS-1:0] ADC_MAX_RESET  = SAMPLE_BITS'(1023);
   localparam logic [SAMPLE_BITS-1:0] OVER_THR_RESET = SAMPLE_BITS'(920);
   localparam logic [FLASH_BITS-1:0]  FLASH_RESET    = FLASH_BITS'(25);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_ADC_MIN        = 3'd0,
      REG_ADC_MAX        = 3'd1,
      REG_RANGE_MODE     = 3'd2,
      REG_OVER_THRESHOLD = 3'd3,
      REG_FLASH_PERIOD   = 3'd4
   } csr_reg_type;

   typedef enum logic [2:0] {
      CORE_IDLE,
      CORE_MUL,
      CORE_DIV,
      CORE_SAT,
      CORE_BCD,
      CORE_DONE
   } core_state_type;

   typedef enum logic {
      TOP_IDLE,
      TOP_BUSY
   } top_state_type;

   typedef struct packed {
      logic start;
      logic ack;
   } core_cmd_type;

   typedef struct packed {
      logic idle;
      logic done;
   } core_stat_type;

   function automatic logic [FS_BITS-1:0] full_scale(input logic [RANGE_BITS-1:0] mode);
      logic [FS_BITS-1:0] fs;
      unique case (mode)
         3'd0:    fs = FS_BITS'(30);
         3'd1:    fs = FS_BITS'(50);
         3'd2:    fs = FS_BITS'(75);
         3'd3:    fs = FS_BITS'(100);
         3'd4:    fs = FS_BITS'(150);
         3'd5:    fs = FS_BITS'(200);
         3'd6:    fs = FS_BITS'(300);
         default: fs = FS_BITS'(500);
      endcase
      return fs;
   endfunction

endpackage

>>> rtl/lcfd_if.sv
// valid/ready channel interfaces for converter samples and display frames
interface lcfd_req_if;
   logic                               valid;
   logic                               ready;
   logic [lcfd_pkg::SAMPLE_BITS-1:0]   adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

interface lcfd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [lcfd_pkg::DIGIT_BITS-1:0]    digit_thousands;
   logic [lcfd_pkg::DIGIT_BITS-1:0]    digit_hundreds;
   logic [lcfd_pkg::DIGIT_BITS-1:0]    digit_tens;
   logic [lcfd_pkg::DIGIT_BITS-1:0]    digit_ones;
   logic [lcfd_pkg::RANGE_BITS-1:0]    range_code;
   logic                               blanked;
   logic                               saturated;

   modport source (output valid, output digit_thousands, output digit_hundreds,
                   output digit_tens, output digit_ones, output range_code,
                   output blanked, output saturated, input ready);
   modport sink   (input valid, input digit_thousands, input digit_hundreds,
                   input digit_tens, input digit_ones, input range_code,
                   input blanked, input saturated, output ready);
endinterface

>>> rtl/lcfd_core.sv
// bit-serial scaler: shift-add multiply, restoring divide, saturate, double-dabble to bcd
module lcfd_core (
   input  logic                                clock,
   input  logic                                reset,
   input  lcfd_pkg::core_cmd_type              cmd,
   input  logic [lcfd_pkg::SAMPLE_BITS-1:0]    num,
   input  logic [lcfd_pkg::SAMPLE_BITS-1:0]    span,
   input  logic [lcfd_pkg::FS_BITS-1:0]        fs,
   input  logic                                zero,
   output lcfd_pkg::core_stat_type             stat,
   output logic [lcfd_pkg::BCD_BITS-1:0]       bcd,
   output logic                                saturated
);

   lcfd_pkg::core_state_type              state_ff, state_in;
   logic [lcfd_pkg::NUM_BITS-1:0]         acc_ff, acc_in;
   logic [lcfd_pkg::NUM_BITS-1:0]         mcand_ff, mcand_in;
   logic [lcfd_pkg::SAMPLE_BITS-1:0]      mplier_ff, mplier_in;
   logic [lcfd_pkg::DIV_BITS-1:0]         div_ff, div_in;
   logic [lcfd_pkg::DIV_BITS-1:0]         rem_ff, rem_in;
   logic                                  zero_ff, zero_in;
   logic [lcfd_pkg::VAL_BITS-1:0]         bin_ff, bin_in;
   logic [lcfd_pkg::BCD_BITS-1:0]         bcd_ff, bcd_in;
   logic                                  sat_ff, sat_in;
   logic [lcfd_pkg::CNT_BITS-1:0]         cnt_ff, cnt_in;

   logic [lcfd_pkg::DIV_BITS:0]           trial;
   logic [lcfd_pkg::DIV_BITS:0]           diff;
   logic                                  qbit;
   logic [lcfd_pkg::BCD_BITS-1:0]         adj;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcfd_pkg::CORE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      zero_ff   <= zero_in;
      bin_ff    <= bin_in;
      bcd_ff    <= bcd_in;
      sat_ff    <= sat_in;
      cnt_ff    <= cnt_in;
   end

   always_comb begin
      state_in  = state_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      zero_in   = zero_ff;
      bin_in    = bin_ff;
      bcd_in    = bcd_ff;
      sat_in    = sat_ff;
      cnt_in    = cnt_ff;

      trial = {rem_ff, acc_ff[lcfd_pkg::NUM_BITS-1]};
      diff  = trial - {1'b0, div_ff};
      qbit  = (trial >= {1'b0, div_ff});

      for (int i = 0; i < 4; i++) begin
         if (bcd_ff[i*lcfd_pkg::DIGIT_BITS +: lcfd_pkg::DIGIT_BITS] >= 4'd5) begin
            adj[i*lcfd_pkg::DIGIT_BITS +: lcfd_pkg::DIGIT_BITS] =
               bcd_ff[i*lcfd_pkg::DIGIT_BITS +: lcfd_pkg::DIGIT_BITS] + 4'd3;
         end else begin
            adj[i*lcfd_pkg::DIGIT_BITS +: lcfd_pkg::DIGIT_BITS] =
               bcd_ff[i*lcfd_pkg::DIGIT_BITS +: lcfd_pkg::DIGIT_BITS];
         end
      end

      unique case (state_ff)
         lcfd_pkg::CORE_IDLE: begin
            if (cmd.start) begin
               // accumulator starts at span so it ends as 2*num*fs + span
               acc_in    = lcfd_pkg::NUM_BITS'(span);
               mcand_in  = lcfd_pkg::NUM_BITS'({fs, 1'b0});
               mplier_in = num;
               div_in    = {span, 1'b0};
               rem_in    = '0;
               zero_in   = zero;
               cnt_in    = '0;
               state_in  = lcfd_pkg::CORE_MUL;
            end
         end
         lcfd_pkg::CORE_MUL: begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[lcfd_pkg::NUM_BITS-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[lcfd_pkg::SAMPLE_BITS-1:1]};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == lcfd_pkg::CNT_BITS'(lcfd_pkg::SAMPLE_BITS - 1)) begin
               cnt_in   = '0;
               state_in = lcfd_pkg::CORE_DIV;
            end
         end
         lcfd_pkg::CORE_DIV: begin
            // quotient bits shift in where numerator bits shift out
            rem_in = qbit ? diff[lcfd_pkg::DIV_BITS-1:0] : trial[lcfd_pkg::DIV_BITS-1:0];
            acc_in = {acc_ff[lcfd_pkg::NUM_BITS-2:0], qbit};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == lcfd_pkg::CNT_BITS'(lcfd_pkg::NUM_BITS - 1)) begin
               cnt_in   = '0;
               state_in = lcfd_pkg::CORE_SAT;
            end
         end
         lcfd_pkg::CORE_SAT: begin
            if (zero_ff) begin
               bin_in = '0;
               sat_in = 1'b0;
            end else if (acc_ff > lcfd_pkg::NUM_BITS'(lcfd_pkg::MAX_SHOWN)) begin
               bin_in = lcfd_pkg::MAX_SHOWN;
               sat_in = 1'b1;
            end else begin
               bin_in = acc_ff[lcfd_pkg::VAL_BITS-1:0];
               sat_in = 1'b0;
            end
            bcd_in   = '0;
            cnt_in   = '0;
            state_in = lcfd_pkg::CORE_BCD;
         end
         lcfd_pkg::CORE_BCD: begin
            {bcd_in, bin_in} = {adj[lcfd_pkg::BCD_BITS-2:0], bin_ff, 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == lcfd_pkg::CNT_BITS'(lcfd_pkg::VAL_BITS - 1)) begin
               cnt_in   = '0;
               state_in = lcfd_pkg::CORE_DONE;
            end
         end
         lcfd_pkg::CORE_DONE: begin
            if (cmd.ack) begin
               state_in = lcfd_pkg::CORE_IDLE;
            end
         end
         default: begin
            state_in = lcfd_pkg::CORE_IDLE;
         end
      endcase
   end

   assign stat.idle = (state_ff == lcfd_pkg::CORE_IDLE);
   assign stat.done = (state_ff == lcfd_pkg::CORE_DONE);
   assign bcd       = bcd_ff;
   assign saturated = sat_ff;

endmodule

>>> rtl/loop_current_flow_display.sv
// top level: config registers, flash control, handshakes and display frame register
//
// Takes one 10-bit converter sample per req transaction and returns at most one
// display frame on rsp: four decimal digits, the range code, a blank flag and a
// saturation flag. The user writes registers through csr_we/csr_index/csr_wdata, one
// per cycle, only while no sample is in flight; the block does not enforce this.
// A sample below over_threshold always gives a frame. At or above it the tick
// counter advances; only when it reaches flash_period does the phase toggle and
// a frame (digits or blank) go out, and such a sample otherwise gives none.
// A sample with no frame never lowers req.ready.
// A sample with a frame runs the bit-serial scaler: SAMPLE_BITS multiply steps,
// NUM_BITS divide steps, one saturate step and VAL_BITS bcd steps. Once it is
// done and the output register is free, rsp.valid rises and req.ready returns in
// the same cycle, so the block takes no new sample while the scaler works on one.
// The frame sits in an output register, so the next sample is taken while it
// waits; if the receiver still stalls when the following frame is done, the
// block holds that frame in the scaler and keeps req.ready low.
// Synchronous reset restores register defaults, clears the tick counter and
// flash phase and drops rsp.valid.
module loop_current_flow_display (
   input  logic                                   clock,
   input  logic                                   reset,
   lcfd_req_if.sink                               req,
   lcfd_rsp_if.source                             rsp,
   input  logic                                   csr_we,
   input  logic [lcfd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [lcfd_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   logic [lcfd_pkg::SAMPLE_BITS-1:0]   adc_min_ff;
   logic [lcfd_pkg::SAMPLE_BITS-1:0]   adc_max_ff;
   logic [lcfd_pkg::RANGE_BITS-1:0]    range_mode_ff;
   logic [lcfd_pkg::SAMPLE_BITS-1:0]   over_thr_ff;
   logic [lcfd_pkg::FLASH_BITS-1:0]    flash_period_ff;

   logic [lcfd_pkg::TICK_BITS-1:0]     tick_ff;
   logic                               phase_ff;
   logic                               dark_ff;
   logic [lcfd_pkg::RANGE_BITS-1:0]    range_ff;

   lcfd_pkg::top_state_type            state_ff, state_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [lcfd_pkg::BCD_BITS-1:0]      digits_ff;
   logic                               rsp_sat_ff;
   logic                               rsp_blank_ff;
   logic [lcfd_pkg::RANGE_BITS-1:0]    rsp_range_ff;

   logic                               accept;
   logic                               over;
   logic [lcfd_pkg::TICK_BITS-1:0]     tick_inc;
   logic                               hit;
   logic                               emit;
   logic                               load;
   lcfd_pkg::core_cmd_type             cmd;
   lcfd_pkg::core_stat_type            stat;
   logic [lcfd_pkg::BCD_BITS-1:0]      core_bcd;
   logic                               core_sat;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         adc_min_ff      <= '0;
         adc_max_ff      <= lcfd_pkg::ADC_MAX_RESET;
         range_mode_ff   <= '0;
         over_thr_ff     <= lcfd_pkg::OVER_THR_RESET;
         flash_period_ff <= lcfd_pkg::FLASH_RESET;
      end else if (csr_we) begin
         unique case (lcfd_pkg::csr_reg_type'(csr_index))
            lcfd_pkg::REG_ADC_MIN:        adc_min_ff      <= csr_wdata[lcfd_pkg::SAMPLE_BITS-1:0];
            lcfd_pkg::REG_ADC_MAX:        adc_max_ff      <= csr_wdata[lcfd_pkg::SAMPLE_BITS-1:0];
            lcfd_pkg::REG_RANGE_MODE:     range_mode_ff   <= csr_wdata[lcfd_pkg::RANGE_BITS-1:0];
            lcfd_pkg::REG_OVER_THRESHOLD: over_thr_ff     <= csr_wdata[lcfd_pkg::SAMPLE_BITS-1:0];
            lcfd_pkg::REG_FLASH_PERIOD:   flash_period_ff <= csr_wdata[lcfd_pkg::FLASH_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req.ready = (state_ff == lcfd_pkg::TOP_IDLE);
   assign accept    = req.valid && req.ready;
   assign over      = (req.adc_sample >= over_thr_ff);
   assign tick_inc  = tick_ff + 1'b1;
   assign hit       = (lcfd_pkg::CMP_BITS'(tick_inc) >= lcfd_pkg::CMP_BITS'(flash_period_ff));
   assign emit      = !over || hit;

   assign cmd.start = accept && emit;
   assign load      = (state_ff == lcfd_pkg::TOP_BUSY) && stat.done
                      && (!rsp_valid_ff || rsp.ready);
   assign cmd.ack   = load;

   lcfd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .num       (req.adc_sample - adc_min_ff),
      .span      (adc_max_ff - adc_min_ff),
      .fs        (lcfd_pkg::full_scale(range_mode_ff)),
      .zero      ((adc_max_ff <= adc_min_ff) || (req.adc_sample <= adc_min_ff)),
      .stat      (stat),
      .bcd       (core_bcd),
      .saturated (core_sat)
   );

   // flash counter and phase
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff  <= '0;
         phase_ff <= 1'b0;
      end else if (accept && over) begin
         if (hit) begin
            tick_ff  <= '0;
            phase_ff <= ~phase_ff;
         end else begin
            tick_ff <= tick_inc;
         end
      end
   end

   // frame attributes captured with the transaction; dark when the phase flips back to zero
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         dark_ff  <= over && phase_ff;
         range_ff <= range_mode_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcfd_pkg::TOP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (load) begin
         rsp_valid_in = 1'b1;
      end
      unique case (state_ff)
         lcfd_pkg::TOP_IDLE: begin
            if (cmd.start) begin
               state_in = lcfd_pkg::TOP_BUSY;
            end
         end
         lcfd_pkg::TOP_BUSY: begin
            if (load) begin
               state_in = lcfd_pkg::TOP_IDLE;
            end
         end
         default: begin
            state_in = lcfd_pkg::TOP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         digits_ff    <= dark_ff ? '0 : core_bcd;
         rsp_sat_ff   <= core_sat && !dark_ff;
         rsp_blank_ff <= dark_ff;
         rsp_range_ff <= range_ff;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.digit_thousands = digits_ff[15:12];
   assign rsp.digit_hundreds  = digits_ff[11:8];
   assign rsp.digit_tens      = digits_ff[7:4];
   assign rsp.digit_ones      = digits_ff[3:0];
   assign rsp.range_code      = rsp_range_ff;
   assign rsp.blanked         = rsp_blank_ff;
   assign rsp.saturated       = rsp_sat_ff;

   a_start_when_core_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> stat.idle)
      else $error("scaler started while busy");

   a_done_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> (state_ff == lcfd_pkg::TOP_BUSY))
      else $error("scaler finished with no transaction pending");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("finished frame not presented");

   a_digits_decimal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (digits_ff[15:12] <= 4'd9) && (digits_ff[11:8] <= 4'd9)
                    && (digits_ff[7:4] <= 4'd9) && (digits_ff[3:0] <= 4'd9))
      else $error("non-decimal digit on display frame");

   a_blank_is_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_blank_ff) |-> (digits_ff == '0) && !rsp_sat_ff)
      else $error("blanked frame carries digits");

endmodule

>>> bench/testbench.sv
// self-checking bench for the loop current flow display: scaling, digits, flash and saturation
`timescale 1ns / 1ps

module testbench;

   typedef struct packed {
      logic [lcfd_pkg::DIGIT_BITS-1:0] thousands;
      logic [lcfd_pkg::DIGIT_BITS-1:0] hundreds;
      logic [lcfd_pkg::DIGIT_BITS-1:0] tens;
      logic [lcfd_pkg::DIGIT_BITS-1:0] ones;
      logic [lcfd_pkg::RANGE_BITS-1:0] range_code;
      logic                            blanked;
      logic                            saturated;
   } frame_type;

   localparam int unsigned FLOW_LIMIT    = 9999;
   localparam int          SAMPLE_TOP    = (1 << lcfd_pkg::SAMPLE_BITS) - 1;
   localparam int          SETTLE_CYCLES = 64;
   localparam int unsigned LIMIT_CYCLES  = 1200000;
   localparam int          RANDOM_ITEMS  = 2000;

   class flow_display_board;
      logic [lcfd_pkg::SAMPLE_BITS-1:0] adc_min;
      logic [lcfd_pkg::SAMPLE_BITS-1:0] adc_max;
      logic [lcfd_pkg::SAMPLE_BITS-1:0] over_threshold;
      logic [lcfd_pkg::RANGE_BITS-1:0]  range_mode;
      logic [lcfd_pkg::FLASH_BITS-1:0]  flash_period;
      logic [lcfd_pkg::TICK_BITS-1:0]   tick_count;
      logic                             flash_phase;
      frame_type                        expected_frames[$];
      int unsigned                      frames_seen;
      int unsigned                      errors;

      function new();
         adc_min          = '0;
         adc_max          = lcfd_pkg::ADC_MAX_RESET;
         over_threshold   = lcfd_pkg::OVER_THR_RESET;
         range_mode       = '0;
         flash_period     = lcfd_pkg::FLASH_RESET;
         tick_count       = '0;
         flash_phase      = 1'b0;
         frames_seen      = 0;
         errors           = 0;
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      function void set_reg(lcfd_pkg::csr_reg_type idx,
                            logic [lcfd_pkg::CSR_DATA_BITS-1:0] data);
         case (idx)
            lcfd_pkg::REG_ADC_MIN:        adc_min        = data[lcfd_pkg::SAMPLE_BITS-1:0];
            lcfd_pkg::REG_ADC_MAX:        adc_max        = data[lcfd_pkg::SAMPLE_BITS-1:0];
            lcfd_pkg::REG_RANGE_MODE:     range_mode     = data[lcfd_pkg::RANGE_BITS-1:0];
            lcfd_pkg::REG_OVER_THRESHOLD: over_threshold = data[lcfd_pkg::SAMPLE_BITS-1:0];
            lcfd_pkg::REG_FLASH_PERIOD:   flash_period   = data[lcfd_pkg::FLASH_BITS-1:0];
            default: ;
         endcase
      endfunction

      // exact round half up of (s - adc_min) * fs / span
      function longint unsigned scaled_flow(logic [lcfd_pkg::SAMPLE_BITS-1:0] s);
         longint unsigned span, num, fs;
         if (adc_max <= adc_min || s <= adc_min) return 0;
         span = adc_max - adc_min;
         num  = s - adc_min;
         case (range_mode)
            3'd0:    fs = 30;
            3'd1:    fs = 50;
            3'd2:    fs = 75;
            3'd3:    fs = 100;
            3'd4:    fs = 150;
            3'd5:    fs = 200;
            3'd6:    fs = 300;
            default: fs = 500;
         endcase
         return (2 * num * fs + span) / (2 * span);
      endfunction

      function frame_type display_frame(longint unsigned flow, logic dark);
         frame_type       f;
         longint unsigned shown;
         shown = dark ? 0 : ((flow > FLOW_LIMIT) ? FLOW_LIMIT : flow);
         f.thousands  = lcfd_pkg::DIGIT_BITS'(shown / 1000);
         f.hundreds   = lcfd_pkg::DIGIT_BITS'((shown / 100) % 10);
         f.tens       = lcfd_pkg::DIGIT_BITS'((shown / 10) % 10);
         f.ones       = lcfd_pkg::DIGIT_BITS'(shown % 10);
         f.range_code = range_mode;
         f.blanked    = dark;
         f.saturated  = !dark && (flow > FLOW_LIMIT);
         return f;
      endfunction

      function void take_sample(logic [lcfd_pkg::SAMPLE_BITS-1:0] s);
         longint unsigned flow;
         logic            emit, dark;
         flow = scaled_flow(s);
         emit = 1'b1;
         dark = 1'b0;
         if (s >= over_threshold) begin
            tick_count = tick_count + 1'b1;
            if (tick_count >= flash_period) begin
               tick_count  = '0;
               flash_phase = ~flash_phase;
               dark        = (flash_phase == 1'b0);
            end else begin
               emit = 1'b0;
            end
         end
         if (emit) begin
            expected_frames.push_back(display_frame(flow, dark));
         end
      endfunction

      task check_frame(frame_type got);
         frame_type want;
         frames_seen++;
         if (expected_frames.size() == 0) begin
            report($sformatf("frame %0d arrived with nothing expected", frames_seen));
            return;
         end
         want = expected_frames.pop_front();
         if (got !== want)
            report($sformatf({"frame %0d: got %0h%0h%0h%0h range %0d blank %0b sat %0b,",
                              " want %0h%0h%0h%0h range %0d blank %0b sat %0b"},
                             frames_seen, got.thousands, got.hundreds, got.tens, got.ones,
                             got.range_code, got.blanked, got.saturated,
                             want.thousands, want.hundreds, want.tens, want.ones,
                             want.range_code, want.blanked, want.saturated));
      endtask
   endclass

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                csr_we;
   logic [lcfd_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [lcfd_pkg::CSR_DATA_BITS-1:0]  csr_wdata;

   lcfd_req_if req_ch();
   lcfd_rsp_if rsp_ch();

   flow_display_board board = new();
   bit                quiet_phase = 1'b0;
   int unsigned       cycles = 0;

   loop_current_flow_display dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_idle();
      int r;
      if (quiet_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int unsigned pick_sample();
      int r, v;
      r = $urandom_range(0, 9);
      case (r)
         0:       v = $urandom_range(0, 1) ? SAMPLE_TOP : 0;
         1:       v = int'(board.adc_min) + int'($urandom_range(0, 4)) - 2;
         2:       v = int'(board.adc_max) + int'($urandom_range(0, 4)) - 2;
         3:       v = int'(board.over_threshold) + int'($urandom_range(0, 4)) - 2;
         default: v = $urandom_range(0, SAMPLE_TOP);
      endcase
      if (v < 0) v = 0;
      if (v > SAMPLE_TOP) v = SAMPLE_TOP;
      return unsigned'(v);
   endfunction

   task automatic send_sample(input int unsigned s);
      logic [lcfd_pkg::SAMPLE_BITS-1:0] sample;
      int                               gap;
      sample = lcfd_pkg::SAMPLE_BITS'(s);
      gap = pick_idle();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.adc_sample <= sample;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      board.take_sample(sample);
   endtask

   // drop valid and wait until every expected frame has been checked, then let the block settle
   task automatic wait_settled();
      req_ch.valid <= 1'b0;
      while (board.expected_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input int unsigned lo, input int unsigned hi,
                               input int unsigned mode, input int unsigned thr,
                               input int unsigned period);
      logic [lcfd_pkg::CSR_DATA_BITS-1:0] vals [5];
      lcfd_pkg::csr_reg_type              idx;
      wait_settled();
      vals = '{lcfd_pkg::CSR_DATA_BITS'(lo), lcfd_pkg::CSR_DATA_BITS'(hi),
               lcfd_pkg::CSR_DATA_BITS'(mode), lcfd_pkg::CSR_DATA_BITS'(thr),
               lcfd_pkg::CSR_DATA_BITS'(period)};
      idx = idx.first();
      csr_we <= 1'b1;
      for (int i = 0; i < 5; i++) begin
         csr_index <= idx;
         csr_wdata <= vals[i];
         @(posedge clock);
         board.set_reg(idx, vals[i]);
         idx = idx.next();
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      int stall;
      stall = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset !== 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            board.check_frame({rsp_ch.digit_thousands, rsp_ch.digit_hundreds,
                               rsp_ch.digit_tens, rsp_ch.digit_ones, rsp_ch.range_code,
                               rsp_ch.blanked, rsp_ch.saturated});
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall = pick_idle();
         end
      end
   end

   initial begin
      int unsigned lo, hi, thr, period, count, r;
      int          sent;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.adc_sample <= '0;
      csr_we            <= 1'b0;
      csr_index         <= lcfd_pkg::REG_ADC_MIN;
      csr_wdata         <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: plain frames, then one over-range tick with no frame
      send_sample(0);
      send_sample(1);
      send_sample(511);
      send_sample(919);
      send_sample(SAMPLE_TOP);

      // below adc_min clamps, above adc_max overshoots, period of one alternates phases
      write_config(100, 900, 7, SAMPLE_TOP, 1);
      send_sample(50);
      send_sample(100);
      send_sample(500);
      send_sample(900);
      send_sample(SAMPLE_TOP);
      send_sample(SAMPLE_TOP);

      // inverted span with every sample over range
      write_config(SAMPLE_TOP, 0, 3, 0, 2);
      send_sample(0);
      send_sample(SAMPLE_TOP);
      send_sample(5);
      send_sample(7);

      // tiny span saturates, longest period never fires here
      write_config(0, 1, 7, SAMPLE_TOP, 16'hFFFF);
      send_sample(SAMPLE_TOP);
      send_sample(2);
      send_sample(SAMPLE_TOP - 1);
      send_sample(1);

      // empty span
      write_config(0, 0, 0, SAMPLE_TOP, 1);
      send_sample(SAMPLE_TOP - 1);
      send_sample(0);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         lo = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 700);
         if ($urandom_range(0, 9) == 0) hi = $urandom_range(0, lo);
         else hi = $urandom_range(lo + 1, SAMPLE_TOP);
         r = $urandom_range(0, 9);
         thr = (r < 2) ? SAMPLE_TOP : ((r < 3) ? 0 : $urandom_range(0, SAMPLE_TOP));
         r = $urandom_range(0, 9);
         period = (r < 6) ? $urandom_range(1, 4) :
                  ((r < 9) ? $urandom_range(5, 30) : $urandom_range(31, 200));
         write_config(lo, hi, $urandom_range(0, 7), thr, period);
         quiet_phase = ($urandom_range(0, 4) == 0);
         count = $urandom_range(50, 250);
         repeat (count) begin
            send_sample(pick_sample());
            sent++;
         end
      end

      wait_settled();
      if (board.errors == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

>>> sim.f
rtl/lcfd_pkg.sv
rtl/lcfd_if.sv
rtl/lcfd_core.sv
rtl/loop_current_flow_display.sv
bench/testbench.sv
